FILE: rtl/kmd_pkg.sv
package kmd_pkg;

   // Fixed field widths of the channels
   localparam int COLUMN_W    = 3;
   localparam int SENSE_W     = 8;
   localparam int TIME_W      = 8;
   localparam int KEY_INDEX_W = 6;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GAP         = 1'd1;

   // Reset values of the configuration registers
   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'hFFFF;
   localparam logic [TIME_W-1:0]  MIN_GAP_RESET   = 8'd5;

   // Debounced state of one key
   typedef enum logic [2:0] {
      KEY_OFF     = 3'd0,
      KEY_PRESS   = 3'd1,
      KEY_HOLD    = 3'd2,
      KEY_RELEASE = 3'd3,
      KEY_INVALID = 3'd4
   } key_state_type;

   // One entry of the per-key state store
   typedef struct packed {
      key_state_type      prev_state;
      key_state_type      cur_state;
      logic [COUNT_W-1:0] active_count;
      logic [COUNT_W-1:0] inactive_count;
      logic [TIME_W-1:0]  decision_time;
   } key_entry_type;

   localparam key_entry_type ENTRY_RESET = '{
      prev_state:     KEY_OFF,
      cur_state:      KEY_OFF,
      active_count:   '0,
      inactive_count: THRESHOLD_RESET,
      decision_time:  '0
   };

   // Control unit states
   typedef enum logic {
      CTRL_IDLE,
      CTRL_BUSY
   } ctrl_state_type;

   // Commands from the control unit to the datapath
   typedef struct packed {
      logic start;
      logic step;
   } dp_cmd_type;

   // Status from the datapath to the control unit
   typedef struct packed {
      logic column_ok;
      logic last_row;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/key_matrix_debounce.sv
// Keyboard matrix debounce and key state tracker.
//
// Request channel (req_*): one strobed column reading per transfer, with the
// active-low row sense byte, the column index, the low eight bits of the
// millisecond tick and a first-scan flag that opens a new scan cycle.
// Response channel (rsp_*): one transfer per row key of that column, in row
// order, with rsp_last set on the final row. A column index at or beyond the
// column count is taken and produces no response.
// Configuration (csr_*): count threshold at index 0, minimum decision gap in
// milliseconds at index 1; csr_ready is always high. Write only while idle.
// Timing: when the response side never stalls, one row is updated per cycle
// after a capture step that takes the item and reads the first key entry;
// the next entry is read while the current one is written back, so the key
// state store has separate read and write ports. The first response comes
// from the entry read at capture and is held in the result register until
// it transfers. A stalled response holds the row walk; the request side is
// stalled until the last row has been written back.
// Reset (synchronous) restores both registers and marks every key entry as
// unwritten, so all keys read as Off with zero active count and an inactive
// count of 65535; no clearing pass is needed.
module key_matrix_debounce
   import kmd_pkg::*;
#(
   parameter int COLUMNS = 7,
   parameter int ROWS    = 7
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_first_scan,
   input  logic [COLUMN_W-1:0]    req_column,
   input  logic [SENSE_W-1:0]     req_sense_bits,
   input  logic [TIME_W-1:0]      req_time_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KEY_INDEX_W-1:0] rsp_key_index,
   output logic [2:0]             rsp_key_state,
   output logic                   rsp_decided,
   output logic                   rsp_changed,
   output logic                   rsp_fault,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   kmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kmd_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_first_scan (req_first_scan),
      .req_column     (req_column),
      .req_sense_bits (req_sense_bits),
      .req_time_ms    (req_time_ms),
      .csr_valid      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_index  (rsp_key_index),
      .rsp_key_state  (rsp_key_state),
      .rsp_decided    (rsp_decided),
      .rsp_changed    (rsp_changed),
      .rsp_fault      (rsp_fault),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: rtl/kmd_ctrl.sv
module kmd_ctrl
   import kmd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands: one row is updated per cycle while the result
   // register can take it.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CTRL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (status.column_ok) begin
                  state_in = CTRL_BUSY;
               end
            end
         end
         CTRL_BUSY: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.last_row) begin
                  state_in = CTRL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // An item is never captured while rows of the previous one are in flight.
   a_no_start_and_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.start && cmd.step))
      else $error("start and step issued together");

   // The final row of a column hands control back to the idle state.
   a_last_row_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.last_row) |=> (state_ff == CTRL_IDLE))
      else $error("control unit did not return to idle after the last row");

   // A step is only issued while the result register is free.
   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> status.out_free)
      else $error("step issued while the result register is full");
`endif

endmodule

FILE: rtl/kmd_datapath.sv
module kmd_datapath
   import kmd_pkg::*;
#(
   parameter int COLUMNS = 7,
   parameter int ROWS    = 7
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic                   req_first_scan,
   input  logic [COLUMN_W-1:0]    req_column,
   input  logic [SENSE_W-1:0]     req_sense_bits,
   input  logic [TIME_W-1:0]      req_time_ms,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KEY_INDEX_W-1:0] rsp_key_index,
   output logic [2:0]             rsp_key_state,
   output logic                   rsp_decided,
   output logic                   rsp_changed,
   output logic                   rsp_fault,
   output logic                   rsp_last
);

   localparam int KEYS = COLUMNS * ROWS;
   localparam int AW   = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [COLUMN_W:0] COLUMN_LIMIT = (COLUMN_W + 1)'(COLUMNS);
   localparam logic [AW-1:0]     KEY_STRIDE   = AW'(COLUMNS);
   localparam logic [RW-1:0]     LAST_ROW     = RW'(ROWS - 1);

   // Configuration registers
   logic [COUNT_W-1:0] threshold_ff;
   logic [TIME_W-1:0]  min_gap_ff;

   // Captured item and row walk
   logic               first_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [ROWS-1:0]    sense_ff;
   logic [RW-1:0]      row_ff;
   logic [AW-1:0]      key_ff;

   // Per-key state store with valid bits standing in for the reset values
   key_entry_type      store [KEYS];
   logic [KEYS-1:0]    entry_valid_ff;
   key_entry_type      rd_data_ff;
   logic               rd_valid_ff;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      key_next;

   // Update logic
   key_entry_type      entry;
   key_entry_type      upd;
   logic               closed;
   logic               active;
   logic               refused;
   logic               decided;
   logic               fault;
   logic               changed;
   logic [TIME_W-1:0]  gap;

   // Result register
   logic                   rsp_valid_ff;
   logic [KEY_INDEX_W-1:0] rsp_key_index_ff;
   key_state_type          rsp_key_state_ff;
   logic                   rsp_decided_ff;
   logic                   rsp_changed_ff;
   logic                   rsp_fault_ff;
   logic                   rsp_last_ff;

   // Status towards the control unit
   assign status.column_ok = ({1'b0, req_column} < COLUMN_LIMIT);
   assign status.last_row  = (row_ff == LAST_ROW);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         min_gap_ff   <= MIN_GAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COUNT_THRESHOLD: threshold_ff <= csr_data;
            CSR_MIN_GAP:         min_gap_ff   <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Item capture and row walk; the sense byte shifts so bit zero is the row
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         first_ff <= req_first_scan;
         time_ff  <= req_time_ms;
         sense_ff <= req_sense_bits[ROWS-1:0];
         row_ff   <= '0;
         key_ff   <= AW'(req_column);
      end else if (cmd.step) begin
         sense_ff <= sense_ff >> 1;
         row_ff   <= row_ff + RW'(1);
         key_ff   <= key_next;
      end
   end

   // The next row's entry is read while the current one is written back
   assign key_next = key_ff + KEY_STRIDE;
   assign rd_en    = cmd.start || (cmd.step && !status.last_row);
   assign rd_addr  = cmd.start ? AW'(req_column) : key_next;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
      if (cmd.step) begin
         store[key_ff] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= entry_valid_ff[rd_addr];
         end
         if (cmd.step) begin
            entry_valid_ff[key_ff] <= 1'b1;
         end
      end
   end

   // Count update and once-per-scan decision for one key
   always_comb begin
      entry   = rd_valid_ff ? rd_data_ff : ENTRY_RESET;
      upd     = entry;
      refused = 1'b0;
      decided = 1'b0;
      fault   = 1'b0;
      gap     = time_ff - entry.decision_time;
      closed  = !sense_ff[0];

      if (first_ff) begin
         upd.prev_state = entry.cur_state;
         upd.cur_state  = KEY_INVALID;
      end

      if (closed) begin
         if (entry.active_count < threshold_ff) begin
            upd.active_count = entry.active_count + COUNT_W'(1);
         end
         upd.inactive_count = entry.inactive_count >> 1;
      end else begin
         if (entry.inactive_count < threshold_ff) begin
            upd.inactive_count = entry.inactive_count + COUNT_W'(1);
         end
         upd.active_count = entry.active_count >> 1;
      end

      active = (upd.active_count > upd.inactive_count);

      if (upd.cur_state == KEY_INVALID) begin
         case (upd.prev_state)
            KEY_PRESS, KEY_HOLD: begin
               if (active) begin
                  upd.cur_state = KEY_HOLD;
               end else if (gap < min_gap_ff) begin
                  refused = 1'b1;
               end else begin
                  upd.cur_state = KEY_RELEASE;
               end
            end
            KEY_RELEASE, KEY_OFF: begin
               if (!active) begin
                  upd.cur_state = KEY_OFF;
               end else if (gap < min_gap_ff) begin
                  refused = 1'b1;
               end else begin
                  upd.cur_state = KEY_PRESS;
               end
            end
            default: begin
               fault = 1'b1;
            end
         endcase

         // A refused flip falls back to the previous state and keeps the time
         if (refused) begin
            upd.cur_state = upd.prev_state;
         end else begin
            upd.decision_time = time_ff;
            decided           = 1'b1;
         end
      end

      changed = (upd.cur_state != upd.prev_state);
   end

   // Result register: loaded on each row step, cleared once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_key_index_ff <= KEY_INDEX_W'(key_ff);
         rsp_key_state_ff <= upd.cur_state;
         rsp_decided_ff   <= decided;
         rsp_changed_ff   <= changed;
         rsp_fault_ff     <= fault;
         rsp_last_ff      <= status.last_row;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_index = rsp_key_index_ff;
   assign rsp_key_state = rsp_key_state_ff;
   assign rsp_decided   = rsp_decided_ff;
   assign rsp_changed   = rsp_changed_ff;
   assign rsp_fault     = rsp_fault_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // Every row step leaves a result waiting in the output register.
   a_step_loads_result: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rsp_valid_ff)
      else $error("row step did not load the result register");

   // The final row's result carries the last flag.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.last_row) |=> rsp_last_ff)
      else $error("last row result without last flag");

   // A fault always counts as a decision and leaves the key invalid.
   a_fault_decides: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && fault) |-> (decided && (upd.cur_state == KEY_INVALID)))
      else $error("fault without decision or with a valid state");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
   import kmd_pkg::*;

   localparam int COLUMNS = 7;
   localparam int ROWS    = 7;
   localparam int KEYS    = COLUMNS * ROWS;
   localparam int SCRIPT_LEN = 14;
   localparam int PHASES  = 6;

   // One column reading, with optional hand-written expectations for its keys
   typedef struct {
      logic                first;
      logic [COLUMN_W-1:0] column;
      logic [SENSE_W-1:0]  sense;
      logic [TIME_W-1:0]   time_ms;
      int                  reps;
      logic                typed;
      key_state_type       t_state;
      logic                t_decided;
      logic                t_changed;
      logic                t_fault;
   } reading_type;

   // What the block should report for one key
   typedef struct {
      logic [KEY_INDEX_W-1:0] key_index;
      key_state_type          key_state;
      logic                   decided;
      logic                   changed;
      logic                   fault;
      logic                   last;
   } key_report_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_first_scan;
   logic [COLUMN_W-1:0]    req_column;
   logic [SENSE_W-1:0]     req_sense_bits;
   logic [TIME_W-1:0]      req_time_ms;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KEY_INDEX_W-1:0] rsp_key_index;
   logic [2:0]             rsp_key_state;
   logic                   rsp_decided;
   logic                   rsp_changed;
   logic                   rsp_fault;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Predicted per-key debounce state and the register copies
   key_state_type      prior_state [KEYS];
   key_state_type      now_state [KEYS];
   logic [COUNT_W-1:0] closed_count [KEYS];
   logic [COUNT_W-1:0] open_count [KEYS];
   logic [TIME_W-1:0]  last_decision [KEYS];
   logic [COUNT_W-1:0] count_limit;
   logic [TIME_W-1:0]  min_gap;

   key_report_type pending_reports [$];
   int             error_count = 0;
   bit             calm = 1'b0;
   int             stall_left = 0;
   logic [TIME_W-1:0]  ms_tick = '0;
   logic [ROWS-1:0]    held_keys [COLUMNS];

   key_matrix_debounce #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_first_scan(req_first_scan),
      .req_column(req_column),
      .req_sense_bits(req_sense_bits),
      .req_time_ms(req_time_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_key_index(rsp_key_index),
      .rsp_key_state(rsp_key_state),
      .rsp_decided(rsp_decided),
      .rsp_changed(rsp_changed),
      .rsp_fault(rsp_fault),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Mostly short pauses, now and then a long one.
   function automatic int pause_len();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 10) return 0;
      if (pick < 14) return $urandom_range(1, 3);
      if (pick < 15) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Debounce one column reading and work out the report for each of its keys.
   task automatic debounce_column(input reading_type r, output key_report_type rep [ROWS],
                                  output int n);
      int k;
      logic decided;
      logic fault;
      logic refused;
      logic busy;
      logic [TIME_W-1:0] elapsed;
      n = 0;
      if (r.column >= COLUMNS) return;
      for (int row = 0; row < ROWS; row++) begin
         k = COLUMNS * row + r.column;
         decided = 1'b0;
         fault = 1'b0;
         refused = 1'b0;
         if (r.first) begin
            prior_state[k] = now_state[k];
            now_state[k] = KEY_INVALID;
         end
         // Saturating count for what was seen, halving for the other
         if (!r.sense[row]) begin
            if (closed_count[k] < count_limit) closed_count[k] = closed_count[k] + 1'b1;
            open_count[k] = open_count[k] >> 1;
         end else begin
            if (open_count[k] < count_limit) open_count[k] = open_count[k] + 1'b1;
            closed_count[k] = closed_count[k] >> 1;
         end
         // One decision per scan cycle, with flips held off inside the gap
         if (now_state[k] == KEY_INVALID) begin
            elapsed = r.time_ms - last_decision[k];
            busy = closed_count[k] > open_count[k];
            case (prior_state[k])
               KEY_PRESS, KEY_HOLD: begin
                  if (busy) now_state[k] = KEY_HOLD;
                  else if (elapsed < min_gap) refused = 1'b1;
                  else now_state[k] = KEY_RELEASE;
               end
               KEY_RELEASE, KEY_OFF: begin
                  if (!busy) now_state[k] = KEY_OFF;
                  else if (elapsed < min_gap) refused = 1'b1;
                  else now_state[k] = KEY_PRESS;
               end
               default: fault = 1'b1;
            endcase
            if (refused) begin
               now_state[k] = prior_state[k];
            end else begin
               last_decision[k] = r.time_ms;
               decided = 1'b1;
            end
         end
         rep[row].key_index = k[KEY_INDEX_W-1:0];
         rep[row].key_state = now_state[k];
         rep[row].decided = decided;
         rep[row].changed = now_state[k] != prior_state[k];
         rep[row].fault = fault;
         rep[row].last = row == ROWS - 1;
         n++;
      end
   endtask

   // Offer one reading, wait for its transfer and queue the key reports.
   task automatic send_reading(input reading_type r);
      key_report_type rep [ROWS];
      int n;
      int gap;
      gap = calm ? 0 : pause_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_scan <= r.first;
      req_column <= r.column;
      req_sense_bits <= r.sense;
      req_time_ms <= r.time_ms;
      do @(posedge clock); while (req_stall);
      debounce_column(r, rep, n);
      for (int i = 0; i < n; i++) begin
         if (r.typed) begin
            rep[i].key_state = r.t_state;
            rep[i].decided = r.t_decided;
            rep[i].changed = r.t_changed;
            rep[i].fault = r.t_fault;
         end
         pending_reports.push_back(rep[i]);
      end
   endtask

   // Hold the request side off until every report is in and the block is quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (ROWS + 4) @(posedge clock);
   endtask

   // Write both registers back to back; csr_valid stays high across the pair.
   task automatic write_settings(input logic [COUNT_W-1:0] limit, input logic [TIME_W-1:0] gap);
      csr_valid <= 1'b1;
      csr_index <= CSR_COUNT_THRESHOLD;
      csr_data <= limit;
      do @(posedge clock); while (!csr_ready);
      count_limit = limit;
      csr_index <= CSR_MIN_GAP;
      csr_data <= {8'($urandom_range(0, 255)), gap};
      do @(posedge clock); while (!csr_ready);
      min_gap = gap;
      csr_valid <= 1'b0;
   endtask

   // Whole scan cycles over a span of columns, with keys held across scans,
   // contact bounce, extra reads and stray readings mixed in.
   task automatic run_scan_phase(input int quota);
      int count;
      int span;
      reading_type r;
      count = 0;
      span = ($urandom_range(0, 2) == 0) ? $urandom_range(0, COLUMNS - 1) :
             ($urandom_range(0, 1) == 1) ? COLUMNS - 1 : $urandom_range(0, 2);
      r.reps = 1;
      r.typed = 1'b0;
      r.t_state = KEY_OFF;
      r.t_decided = 1'b0;
      r.t_changed = 1'b0;
      r.t_fault = 1'b0;
      while (count < quota) begin
         calm = $urandom_range(0, 4) == 0;
         for (int c = 0; c <= span; c++)
            for (int row = 0; row < ROWS; row++)
               if ($urandom_range(0, 11) == 0) held_keys[c][row] = ~held_keys[c][row];
         for (int c = 0; c <= span; c++) begin
            if ($urandom_range(0, 9) == 0) begin
               r.first = 1'($urandom_range(0, 1));
               r.column = COLUMN_W'($urandom_range(0, 7));
               r.sense = SENSE_W'($urandom_range(0, 255));
               r.time_ms = ms_tick;
               send_reading(r);
               if (r.column < COLUMNS) count++;
            end
            r.first = 1'b1;
            r.column = COLUMN_W'(c);
            r.sense = {1'($urandom_range(0, 1)), ~held_keys[c]};
            if ($urandom_range(0, 15) == 0) r.sense[$urandom_range(0, 7)] ^= 1'b1;
            r.time_ms = ms_tick;
            send_reading(r);
            count++;
            if ($urandom_range(0, 5) == 0) begin
               r.first = $urandom_range(0, 3) == 0;
               r.sense = {1'($urandom_range(0, 1)), ~held_keys[c]};
               if ($urandom_range(0, 3) == 0) r.sense[$urandom_range(0, 7)] ^= 1'b1;
               send_reading(r);
               count++;
            end
            ms_tick = ms_tick + 8'($urandom_range(0, 1));
         end
         ms_tick = ms_tick + 8'($urandom_range(0, 3));
         if ($urandom_range(0, 19) == 0) ms_tick = TIME_W'($urandom_range(0, 255));
      end
   endtask

   // Response side stalls in runs of random length.
   always @(posedge clock) begin : stall_gen
      int len;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            len = pause_len();
            rsp_stall <= len != 0;
            stall_left <= (len != 0) ? len - 1 : 0;
         end
      end
   end

   // Each response transfer is checked against the oldest outstanding report.
   always @(posedge clock) begin : report_check
      key_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("response transfer with no report outstanding, key_index %0d",
                   rsp_key_index);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_key_index !== want.key_index) begin
               $error("key_index expected %0d actual %0d", want.key_index, rsp_key_index);
               error_count++;
            end
            if (rsp_key_state !== want.key_state) begin
               $error("key_state expected %0d actual %0d (key %0d)", want.key_state,
                      rsp_key_state, want.key_index);
               error_count++;
            end
            if (rsp_decided !== want.decided) begin
               $error("decided expected %0d actual %0d (key %0d)", want.decided,
                      rsp_decided, want.key_index);
               error_count++;
            end
            if (rsp_changed !== want.changed) begin
               $error("changed expected %0d actual %0d (key %0d)", want.changed,
                      rsp_changed, want.key_index);
               error_count++;
            end
            if (rsp_fault !== want.fault) begin
               $error("fault expected %0d actual %0d (key %0d)", want.fault,
                      rsp_fault, want.key_index);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0d actual %0d (key %0d)", want.last,
                      rsp_last, want.key_index);
               error_count++;
            end
         end
      end
   end

   // Hard limit on the run.
   initial begin
      #5000000;
      $display("key_matrix_debounce regression: fail");
      $finish;
   end

   initial begin : stimulus
      // Directed readings. Column two is held closed until it presses, with
      // the tick wrapping through 255, then opened until it releases; flips
      // inside the minimum gap are refused on the way in and out.
      reading_type script [SCRIPT_LEN] = '{
         '{1'b1, 3'd0, 8'hFF, 8'd0,   1,  1'b1, KEY_OFF, 1'b1, 1'b0, 1'b0},
         '{1'b0, 3'd7, 8'h00, 8'd0,   1,  1'b1, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b0, 3'd1, 8'h00, 8'd0,   1,  1'b1, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd6, 8'hFF, 8'd255, 1,  1'b1, KEY_OFF, 1'b1, 1'b0, 1'b0},
         '{1'b1, 3'd2, 8'h00, 8'd243, 13, 1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd2, 8'h00, 8'd1,   1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd2, 8'h00, 8'd4,   1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd2, 8'h00, 8'd5,   1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b0, 3'd2, 8'hFF, 8'd6,   1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd2, 8'hFF, 8'd7,   2,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd2, 8'hFF, 8'd20,  1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd2, 8'hFF, 8'd21,  1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd3, 8'hAA, 8'd100, 1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0},
         '{1'b1, 3'd5, 8'h55, 8'd128, 1,  1'b0, KEY_OFF, 1'b0, 1'b0, 1'b0}
      };
      logic [COUNT_W-1:0] limit_plan [PHASES];
      logic [TIME_W-1:0]  gap_plan [PHASES];
      reading_type r;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_first_scan <= 1'b0;
      req_column <= '0;
      req_sense_bits <= '1;
      req_time_ms <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_COUNT_THRESHOLD;
      csr_data <= '0;

      count_limit = THRESHOLD_RESET;
      min_gap = MIN_GAP_RESET;
      for (int k = 0; k < KEYS; k++) begin
         prior_state[k] = KEY_OFF;
         now_state[k] = KEY_OFF;
         closed_count[k] = '0;
         open_count[k] = THRESHOLD_RESET;
         last_decision[k] = '0;
      end
      for (int c = 0; c < COLUMNS; c++) held_keys[c] = '0;

      limit_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom_range(2, 40)),
                     16'($urandom_range(0, 65535)), 16'h0003};
      gap_plan = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(0, 10)),
                   8'($urandom_range(0, 255)), 8'd5};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings
      calm = $urandom_range(0, 1) == 1;
      foreach (script[i]) begin
         for (int rep = 0; rep < script[i].reps; rep++) begin
            r = script[i];
            r.time_ms = script[i].time_ms + 8'(rep);
            send_reading(r);
         end
      end
      ms_tick = 8'd40;

      // Random scan cycles under a series of settings
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_settings(limit_plan[p], gap_plan[p]);
         run_scan_phase(55);
      end

      wait_idle();
      if (error_count == 0) begin
         $display("key_matrix_debounce regression: pass");
      end else begin
         $display("key_matrix_debounce regression: fail");
      end
      $finish;
   end

endmodule

FILE: key_matrix_debounce.f
rtl/kmd_pkg.sv
rtl/kmd_ctrl.sv
rtl/kmd_datapath.sv
rtl/key_matrix_debounce.sv
dv/testbench.sv
